// ----- sv/deq_pkg.sv -----
package deq_pkg;

	// Default geometry of the ring store.
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed field widths on the stream ports.
	localparam int REQ_W      = 3;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 5;
	localparam int S_TDATA_W  = 32;
	localparam int S_TUSER_W  = 8;
	localparam int M_TDATA_W  = 40;
	localparam int M_TUSER_W  = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_PEEK_FRONT = 3'd4,
		REQ_PEEK_BACK  = 3'd5
	} req_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// ----- sv/deq_ram.sv -----
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read data; the read data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- sv/double_ended_queue_core.sv -----
// A request accepted at a clock edge is registered in stage 1 and then in the output register,
// which raises m_tvalid; the result beat is taken at an edge where m_tready is high.
// Throughput: one request per cycle, sustained, as long as the result side keeps taking beats.
// Each request makes at most one access to the single-port ring memory, at its accept edge.
// Reset (arst_n low, asynchronous) empties the queue and drops any result in flight.
// Memory contents are not cleared; only entries written since reset are ever read.
module double_ended_queue_core import deq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Request side.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] push_value
	input  logic [S_TUSER_W-1:0] s_tuser,  // [2:0] req_type, [7:3] zero
	// Result side.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [31:0] read_value, [36:32] item_count, [39:37] zero
	output logic [M_TUSER_W-1:0] m_tuser   // [1:0] status, [7:2] zero
);

	// Index width for the ring, count width that can hold DEPTH itself, and a sum
	// width for front plus count, which stays below twice the depth.
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	// Queue control state: index of the front entry and number of items held.
	logic [IW-1:0] front_q;
	logic [CW-1:0] cnt_q;

	// Request decode and the next state.
	req_e_t          req;
	logic            accept;
	logic            full;
	logic            empty;
	logic [IW-1:0]   front_dec;
	logic [IW-1:0]   front_inc;
	logic [SW-1:0]   sum;
	logic [SW-1:0]   sum_m1;
	logic [IW-1:0]   tail_idx;
	logic [IW-1:0]   back_idx;
	logic [IW-1:0]   front_nxt;
	logic [CW-1:0]   cnt_nxt;
	logic            mem_we;
	logic            mem_re;
	logic [IW-1:0]   mem_addr;
	status_t         status_nxt;
	logic [DATA_WIDTH-1:0] mem_rdata;

	// Stage 1 holds a request whose memory read (if any) is under way.
	logic            valid_s1;
	logic            rd_s1;
	status_t         status_s1;
	logic [CW-1:0]   cnt_s1;
	logic            adv_s1;

	// Output register, which parts the result side from the request side.
	logic            out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	status_t         out_status_q;
	logic [CW-1:0]   out_cnt_q;

	assign req    = req_e_t'(s_tuser[REQ_W-1:0]);
	assign accept = s_tvalid && s_tready;
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);

	// Ring arithmetic. Both operands stay in range, so each wrap is one compare
	// and at most one subtract of the depth.
	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
	assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);
	assign sum       = SW'(front_q) + SW'(cnt_q);
	assign sum_m1    = sum - SW'(1);
	assign tail_idx  = (sum >= SW'(DEPTH)) ? IW'(sum - SW'(DEPTH)) : IW'(sum);
	// Only used when the queue holds at least one item, so the sum is nonzero.
	assign back_idx  = (sum_m1 >= SW'(DEPTH)) ? IW'(sum_m1 - SW'(DEPTH)) : IW'(sum_m1);

	always_comb begin
		front_nxt  = front_q;
		cnt_nxt    = cnt_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = front_q;
		status_nxt = ST_OK;
		case (req) inside
			REQ_PUSH_FRONT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					mem_we    = 1'b1;
					mem_addr  = front_dec;
					front_nxt = front_dec;
					cnt_nxt   = cnt_q + CW'(1);
				end
			end
			REQ_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					mem_we   = 1'b1;
					mem_addr = tail_idx;
					cnt_nxt  = cnt_q + CW'(1);
				end
			end
			REQ_POP_FRONT, REQ_PEEK_FRONT: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					mem_addr = front_q;
					if (req == REQ_POP_FRONT) begin
						front_nxt = front_inc;
						cnt_nxt   = cnt_q - CW'(1);
					end
				end
			end
			REQ_POP_BACK, REQ_PEEK_BACK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					mem_addr = back_idx;
					if (req == REQ_POP_BACK) begin
						cnt_nxt = cnt_q - CW'(1);
					end
				end
			end
			default: begin
				// Unused request codes change nothing and report success.
			end
		endcase
	end

	// The ring store. A write and a later read of the same entry come from different
	// requests and so at different edges, so the registered read sees the new word.
	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (accept && mem_we),
		.re    (accept && mem_re),
		.addr  (mem_addr),
		.wdata (DATA_WIDTH'(s_tdata[VALUE_W-1:0])),
		.rdata (mem_rdata)
	);

	// Queue state changes at the accept edge; it never waits on read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			front_q <= front_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// Stage 1 moves on when the output register is free or being emptied. The
	// memory read data holds while stage 1 waits because no new request enters.
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= mem_re;
			status_s1 <= status_nxt;
			cnt_s1    <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	// The stored word is read back sign-extended; failed requests and pushes
	// report zero.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_value_q  <= rd_s1 ? VALUE_W'($signed(mem_rdata)) : '0;
			out_status_q <= status_s1;
			out_cnt_q    <= cnt_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_TDATA_W - VALUE_W - COUNT_W)'(0), COUNT_W'(out_cnt_q), out_value_q};
	assign m_tuser  = {(M_TUSER_W - STATUS_W)'(0), out_status_q};

	// The count never exceeds the depth and the front index stays on the ring.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("held count exceeds depth");
	assert property (@(posedge clk) disable iff (!arst_n) front_q <= IW'(DEPTH - 1))
		else $error("front index off the ring");
	// A successful push grows the count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !full && (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK)
		|=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("push did not grow the count");
	// A stalled stage 1 must block the request side, or its read data is lost.
	assert property (@(posedge clk) disable iff (!arst_n) valid_s1 && !adv_s1 |-> !s_tready)
		else $error("request accepted over a stalled read");
	// An empty or full status always carries a zero word.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == ST_EMPTY || out_status_q == ST_FULL)
		|-> out_value_q == '0)
		else $error("failed request returned a word");

endmodule

// ----- tb/tb_double_ended_queue_core.sv -----
`timescale 1ns / 1ps

module tb_double_ended_queue_core;
	import deq_pkg::*;

	localparam int RING_DEPTH = DEPTH_DEF;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int RAND_REQS  = 450;

	// Request codes the block treats as no operation.
	localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		status_t            status;
		logic [COUNT_W-1:0] item_count;
	} deq_result_t;

	// One row of the directed table. A row with pinned set carries its own
	// expected result; every other row is checked against the ring predictor.
	typedef struct packed {
		logic [REQ_W-1:0]   req;
		logic [VALUE_W-1:0] word;
		logic [4:0]         reps;
		logic               pinned;
		deq_result_t        want;
	} dir_row_t;

	localparam int DIR_ROWS = 16;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// Every pop and peek on the empty queue after reset reports empty.
		'{REQ_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
		'{REQ_POP_BACK,   32'hFFFF_FFFF, 5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
		'{REQ_PEEK_FRONT, 32'h0000_0000, 5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
		'{REQ_PEEK_BACK,  32'h0000_0000, 5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
		// Unused code: nothing happens, status ok.
		'{REQ_UNUSED_6,   32'hFFFF_FFFF, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd0}},
		// Largest and smallest words; the front push wraps the index below zero.
		'{REQ_PUSH_BACK,  32'h7FFF_FFFF, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd1}},
		'{REQ_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd2}},
		'{REQ_PEEK_FRONT, 32'h1234_5678, 5'd1, 1'b1, '{32'h8000_0000, ST_OK, 5'd2}},
		'{REQ_PEEK_BACK,  32'h0000_0000, 5'd1, 1'b1, '{32'h7FFF_FFFF, ST_OK, 5'd2}},
		'{REQ_UNUSED_7,   32'hDEAD_BEEF, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd2}},
		// Fill up to the full depth from both ends.
		'{REQ_PUSH_BACK,  32'hFFFF_FFFF, 5'd7, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'h0000_0000, 5'd7, 1'b0, '0},
		// Pushes to a full queue are dropped.
		'{REQ_PUSH_FRONT, 32'h5A5A_5A5A, 5'd1, 1'b1, '{32'h0, ST_FULL, 5'd16}},
		'{REQ_PUSH_BACK,  32'hA5A5_A5A5, 5'd1, 1'b1, '{32'h0, ST_FULL, 5'd16}},
		'{REQ_POP_BACK,   32'h0000_0000, 5'd1, 1'b1, '{32'hFFFF_FFFF, ST_OK, 5'd15}},
		'{REQ_POP_FRONT,  32'h0000_0000, 5'd1, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // [31:0] push_value
	logic [S_TUSER_W-1:0] s_tuser = '0;   // [2:0] req_type, [7:3] zero
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;   // [31:0] read_value, [36:32] item_count, [39:37] zero
	logic [M_TUSER_W-1:0] m_tuser;   // [1:0] status, [7:2] zero

	// A pinned expectation travels beside the request beat it belongs to.
	logic        pin_valid = 1'b0;
	deq_result_t pin_result = '0;

	// Predictor state: a copy of the ring store, its front index and count.
	logic [VALUE_W-1:0] ring_mem [RING_DEPTH];
	logic [IDX_W-1:0]   ring_front = '0;
	logic [COUNT_W-1:0] ring_count = '0;

	deq_result_t pending_results [$];
	int          mismatch_count = 0;

	// When set, the sender or the receiver runs without any idle cycles.
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	double_ended_queue_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the predicted ring and returns its result.
	function automatic deq_result_t apply_request(logic [REQ_W-1:0] req,
			logic [VALUE_W-1:0] word);
		deq_result_t      res;
		logic [IDX_W-1:0] back_idx;
		res = '0;
		res.status = ST_OK;
		back_idx = IDX_W'(ring_front + ring_count - 1);
		case (req)
			REQ_PUSH_FRONT: begin
				if (ring_count == RING_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					ring_front = ring_front - 1'b1;
					ring_mem[ring_front] = word;
					ring_count = ring_count + 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (ring_count == RING_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					ring_mem[IDX_W'(ring_front + ring_count)] = word;
					ring_count = ring_count + 1'b1;
				end
			end
			REQ_POP_FRONT, REQ_PEEK_FRONT: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.read_value = ring_mem[ring_front];
					if (req == REQ_POP_FRONT) begin
						ring_front = ring_front + 1'b1;
						ring_count = ring_count - 1'b1;
					end
				end
			end
			REQ_POP_BACK, REQ_PEEK_BACK: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.read_value = ring_mem[back_idx];
					if (req == REQ_POP_BACK) begin
						ring_count = ring_count - 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.item_count = ring_count;
		return res;
	endfunction

	// Picks one of the four pop and peek codes at random.
	function automatic logic [REQ_W-1:0] pick_read_req();
		case ($urandom_range(0, 3))
			0: return REQ_POP_FRONT;
			1: return REQ_POP_BACK;
			2: return REQ_PEEK_FRONT;
			default: return REQ_PEEK_BACK;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Presents one request beat after a random gap and waits for its accept.
	// A gap of zero keeps s_tvalid high straight into the next beat.
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] word,
			input logic pinned, input deq_result_t want);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid   <= 1'b1;
		s_tuser    <= {{(S_TUSER_W-REQ_W){1'b0}}, req};
		s_tdata    <= word;
		pin_valid  <= pinned;
		pin_result <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	// Scoreboard. On each accepted request the predictor (or the pinned row)
	// queues one expected result; each accepted result beat is compared with
	// the oldest one, field by field.
	always @(posedge clk) begin : scoreboard
		deq_result_t predicted;
		deq_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predicted = apply_request(s_tuser[REQ_W-1:0], s_tdata[VALUE_W-1:0]);
				pending_results.push_back(pin_valid ? pin_result : predicted);
			end
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result beat with no request waiting for it");
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[31:0] !== want.read_value)
						report_mismatch($sformatf("read_value %h, expected %h",
							m_tdata[31:0], want.read_value));
					if (m_tuser[1:0] !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							m_tuser[1:0], want.status));
					if (m_tdata[36:32] !== want.item_count)
						report_mismatch($sformatf("item_count %0d, expected %0d",
							m_tdata[36:32], want.item_count));
				end
			end
		end
	end

	// Result side: stalls a random number of cycles before taking each beat, none when rx_steady is set.
	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin : stimulus
		int               push_pct;
		int               pick;
		logic [REQ_W-1:0] req;
		logic [VALUE_W-1:0] word;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			for (int k = 0; k < dir_rows[i].reps; k++) begin
				send_request(dir_rows[i].req, dir_rows[i].word, dir_rows[i].pinned,
					dir_rows[i].want);
			end
		end

		// Random part, in chunks with a push bias so that the queue swings
		// between full and empty, and with steady stretches on either side.
		push_pct = 50;
		for (int n = 0; n < RAND_REQS; n++) begin
			if (n % 30 == 0) begin
				case ($urandom_range(0, 4))
					0: push_pct = 95;
					1: push_pct = 80;
					2: push_pct = 50;
					3: push_pct = 20;
					default: push_pct = 5;
				endcase
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 2)
				req = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
			else if (pick < push_pct)
				req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			else
				req = pick_read_req();
			case ($urandom_range(0, 7))
				0: word = 32'h8000_0000;
				1: word = 32'h7FFF_FFFF;
				default: word = $urandom;
			endcase
			send_request(req, word, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// Wait so that the last accepted request has been queued
		// by the scoreboard before the drain check starts.
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/deq_pkg.sv
sv/deq_ram.sv
sv/double_ended_queue_core.sv
tb/tb_double_ended_queue_core.sv
